@@ hw/rtl/ddmf_pkg.sv @@
// Shared types, widths, register codes and saturation helper for the drive step core.
package ddmf_pkg;

	localparam int Q_W     = 32;
	localparam int REG_W   = 31;
	localparam int IDX_W   = 3;
	localparam int MUL_A_W = 36;
	localparam int MUL_B_W = 33;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int T_W     = 48;
	localparam int M_W     = 35;
	localparam int QD_W    = 36;

	typedef logic signed [Q_W-1:0] q32_t;
	typedef logic [REG_W-1:0]      creg_t;

	typedef struct packed {
		creg_t mu;
		creg_t damp;
		creg_t decay;
		creg_t gain;
	} wcfg_t;

	typedef struct packed {
		q32_t speed;
		q32_t aux;
	} wst_t;

	typedef struct packed {
		logic clip;
		q32_t val;
	} sat_t;

	typedef enum logic [4:0] {
		IDLE,
		T_RED,
		T_OM,
		T_RATE,
		T_GAIN,
		T_TURN,
		T_RDRV,
		T_LDRV,
		W_SPD,
		W_T,
		W_CLAMP,
		W_M,
		W_QMUL,
		W_Q0,
		W_RMUL,
		W_R,
		W_FIX,
		W_SPEED,
		W_AUX1,
		W_AUX2,
		W_AUX3,
		O_DIFF,
		O_MUL,
		O_ANG
	} st_t;

	localparam logic [IDX_W-1:0] REG_FRIC_R  = 3'd0;
	localparam logic [IDX_W-1:0] REG_DAMP_R  = 3'd1;
	localparam logic [IDX_W-1:0] REG_DECAY_R = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAIN_R  = 3'd3;
	localparam logic [IDX_W-1:0] REG_FRIC_L  = 3'd4;
	localparam logic [IDX_W-1:0] REG_DAMP_L  = 3'd5;
	localparam logic [IDX_W-1:0] REG_DECAY_L = 3'd6;
	localparam logic [IDX_W-1:0] REG_GAIN_L  = 3'd7;

	localparam logic signed [SUM_W-1:0] Q_MAX = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [SUM_W-1:0] Q_MIN = ~Q_MAX;

	function automatic sat_t sat32(input logic signed [SUM_W-1:0] x);
		sat_t r;
		if (x > Q_MAX) begin
			r.clip = 1'b1;
			r.val  = Q_MAX[Q_W-1:0];
		end else if (x < Q_MIN) begin
			r.clip = 1'b1;
			r.val  = Q_MIN[Q_W-1:0];
		end else begin
			r.clip = 1'b0;
			r.val  = x[Q_W-1:0];
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/ddmf_mul.sv @@
// Shared signed multiplier with optional half-LSB rounding bias and registered product.
module ddmf_mul #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic                                  rnd,
	input  logic signed [ddmf_pkg::MUL_A_W-1:0]   a,
	input  logic signed [ddmf_pkg::MUL_B_W-1:0]   b,
	output logic signed [ddmf_pkg::PROD_W-1:0]    p
);
	import ddmf_pkg::*;

	localparam logic signed [PROD_W-1:0] HALF = {{(PROD_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] p_q;

	assign prod = PROD_W'(a) * PROD_W'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= prod + (rnd ? HALF : '0);
		end
	end

	assign p = p_q;

endmodule

@@ hw/rtl/diff_drive_motor_friction_step_core.sv @@
// Two-wheel drive step core: one joystick sample in, one Q-format wheel/body state out.
// A step skips the two turn-gain products when |joy_forward| < ZERO_BAND, and each wheel
//   pass repeats its remainder fix step until the remainder lies in [0, 2*STEP_RATE).
// Inputs: no new beat is taken before the step ends; in_stall is high for the whole step as
//   every product uses the single shared multiplier. A held result blocks only the next finish.
// Reset: arst_n clears wheel state, configuration registers and the output valid.
module diff_drive_motor_friction_step_core #(
	parameter int FRAC_BITS      = 16,
	parameter int STEP_RATE      = 25,
	parameter int TURN_RATE      = 65536,
	parameter int TURN_REDUCTION = 0,
	parameter int INV_WHEELBASE  = 65536,
	parameter int ZERO_BAND      = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [ddmf_pkg::IDX_W-1:0]        wr_index,
	input  logic [ddmf_pkg::REG_W-1:0]        wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              new_case,
	input  logic signed [31:0]                init_left_speed,
	input  logic signed [31:0]                init_left_aux,
	input  logic signed [31:0]                init_right_speed,
	input  logic signed [31:0]                init_right_aux,
	input  logic signed [31:0]                joy_forward,
	input  logic signed [31:0]                joy_turn,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [31:0]                linear_velocity,
	output logic signed [31:0]                angular_velocity,
	output logic signed [31:0]                left_wheel_speed,
	output logic signed [31:0]                right_wheel_speed,
	output logic signed [31:0]                left_motor_drive,
	output logic signed [31:0]                right_motor_drive,
	output logic signed [31:0]                left_friction,
	output logic signed [31:0]                right_friction,
	output logic                              saturated
);
	import ddmf_pkg::*;

	localparam int     DIV      = 2 * STEP_RATE;
	localparam int     RECIP_SH = 32;
	localparam longint RECIP    = (longint'(1) << RECIP_SH) / DIV;
	localparam int     FIX_MAX  = 9;

	localparam logic signed [MUL_B_W-1:0] B_TRED  = MUL_B_W'(TURN_REDUCTION);
	localparam logic signed [MUL_B_W-1:0] B_TRATE = MUL_B_W'(TURN_RATE);
	localparam logic signed [MUL_B_W-1:0] B_STEP  = MUL_B_W'(STEP_RATE);
	localparam logic signed [MUL_B_W-1:0] B_INVWB = MUL_B_W'(INV_WHEELBASE);
	localparam logic signed [MUL_B_W-1:0] B_RECIP = MUL_B_W'(RECIP);
	localparam logic signed [MUL_B_W-1:0] B_DIV   = MUL_B_W'(DIV);
	localparam logic signed [SUM_W-1:0]   ONE     = SUM_W'(1) <<< FRAC_BITS;
	localparam logic signed [32:0]        ZB      = 33'(ZERO_BAND);
	localparam logic signed [M_W-1:0]     M_BIAS  = M_W'(STEP_RATE);
	localparam logic signed [QD_W-1:0]    DIV_Q   = QD_W'(DIV);
	localparam logic signed [QD_W-1:0]    FIX_LO  = QD_W'(-FIX_MAX * DIV);
	localparam logic signed [QD_W-1:0]    FIX_HI  = QD_W'((FIX_MAX + 1) * DIV);
	localparam q32_t                      GAIN_BYP = 32'(TURN_RATE);

	st_t state_q, state_nx;

	wcfg_t wcfg_q [2];
	wst_t  wst_q [2];
	q32_t  drv_q [2];
	q32_t  fric_q [2];
	logic  w_q;
	logic  sat_q;
	logic  out_valid_q;

	q32_t                    fwd_q, turn_q, om_q, gain_q, f_q, sn_q;
	logic signed [T_W-1:0]   t_q;
	logic signed [M_W-1:0]   m_q;
	logic signed [QD_W-1:0]  q_q, r_q;
	logic signed [SUM_W-1:0] acc_q;
	logic signed [32:0]      diff_q;

	q32_t lin_q, ang_q, lspd_q, rspd_q, ldrv_q, rdrv_q, lfr_q, rfr_q;
	logic osat_q;

	logic                      mul_en, mul_rnd;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [SUM_W-1:0]   prx;

	wcfg_t cc;
	wst_t  cs;
	q32_t  cdrv;

	logic                    accept, ld_out, bypass;
	logic signed [32:0]      fwd_ext;
	logic signed [T_W-1:0]   t_nx, mu_w;
	q32_t                    f_nx;
	logic signed [M_W-1:0]   m_nx;
	logic signed [QD_W-1:0]  r_nx;
	logic signed [33:0]      lin_sum;
	sat_t                    om_s, gain_s, rdrv_s, ldrv_s, sn_s, aux_s, ang_s;

	ddmf_mul #(
		.FRAC_BITS(FRAC_BITS)
	) u_mul (
		.clk (clk),
		.en  (mul_en),
		.rnd (mul_rnd),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign cc   = wcfg_q[w_q];
	assign cs   = wst_q[w_q];
	assign cdrv = drv_q[w_q];

	assign in_stall = (state_q != IDLE);
	assign accept   = in_valid && !in_stall;
	assign ld_out   = (state_q == O_ANG) && (!out_valid_q || !out_stall);
	assign fwd_ext  = 33'(joy_forward);
	assign bypass   = (fwd_ext < ZB) && (fwd_ext > -ZB);

	assign prx     = SUM_W'(prod >>> FRAC_BITS);
	assign om_s    = sat32(ONE - prx);
	assign gain_s  = sat32(prx);
	assign rdrv_s  = sat32(SUM_W'(fwd_q) + prx);
	assign ldrv_s  = sat32(SUM_W'(fwd_q) - acc_q);
	assign sn_s    = sat32(SUM_W'(cs.speed) + SUM_W'(q_q));
	assign aux_s   = sat32(acc_q + prx);
	assign ang_s   = sat32(prx);
	assign t_nx    = -T_W'(prod) - T_W'(cs.aux);
	assign mu_w    = T_W'({1'b0, cc.mu});
	assign m_nx    = ((M_W'(cs.aux) + M_W'(f_q)) <<< 1) + M_BIAS;
	assign r_nx    = QD_W'(m_q) - QD_W'(prod);
	assign lin_sum = 34'(wst_q[0].speed) + 34'(wst_q[1].speed) + 34'sd1;

	always_comb begin
		if (t_q > mu_w) begin
			f_nx = q32_t'(mu_w[31:0]);
		end else if (t_q < -mu_w) begin
			f_nx = q32_t'(-mu_w[31:0]);
		end else begin
			f_nx = t_q[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		mul_en   = 1'b0;
		mul_rnd  = 1'b1;
		mul_a    = MUL_A_W'(fwd_q);
		mul_b    = B_TRED;
		case (state_q)
			IDLE: begin
				if (accept) begin
					state_nx = bypass ? T_TURN : T_RED;
				end
			end
			T_RED: begin
				mul_en   = 1'b1;
				state_nx = T_OM;
			end
			T_OM:   state_nx = T_RATE;
			T_RATE: begin
				mul_en   = 1'b1;
				mul_a    = MUL_A_W'(om_q);
				mul_b    = B_TRATE;
				state_nx = T_GAIN;
			end
			T_GAIN: state_nx = T_TURN;
			T_TURN: begin
				mul_en   = 1'b1;
				mul_a    = MUL_A_W'(gain_q);
				mul_b    = MUL_B_W'(turn_q);
				state_nx = T_RDRV;
			end
			T_RDRV: state_nx = T_LDRV;
			T_LDRV: state_nx = W_SPD;
			W_SPD: begin
				mul_en   = 1'b1;
				mul_rnd  = 1'b0;
				mul_a    = MUL_A_W'(cs.speed);
				mul_b    = B_STEP;
				state_nx = W_T;
			end
			W_T:     state_nx = W_CLAMP;
			W_CLAMP: state_nx = W_M;
			W_M:     state_nx = W_QMUL;
			W_QMUL: begin
				mul_en   = 1'b1;
				mul_rnd  = 1'b0;
				mul_a    = MUL_A_W'(m_q);
				mul_b    = B_RECIP;
				state_nx = W_Q0;
			end
			W_Q0: state_nx = W_RMUL;
			W_RMUL: begin
				mul_en   = 1'b1;
				mul_rnd  = 1'b0;
				mul_a    = MUL_A_W'(q_q);
				mul_b    = B_DIV;
				state_nx = W_R;
			end
			W_R: state_nx = W_FIX;
			W_FIX: begin
				if (r_q >= 0 && r_q < DIV_Q) begin
					state_nx = W_SPEED;
				end
			end
			W_SPEED: begin
				mul_en   = 1'b1;
				mul_a    = MUL_A_W'(cs.speed);
				mul_b    = MUL_B_W'({1'b0, cc.damp});
				state_nx = W_AUX1;
			end
			W_AUX1: begin
				mul_en   = 1'b1;
				mul_a    = MUL_A_W'(cs.aux);
				mul_b    = MUL_B_W'({1'b0, cc.decay});
				state_nx = W_AUX2;
			end
			W_AUX2: begin
				mul_en   = 1'b1;
				mul_a    = MUL_A_W'(cdrv);
				mul_b    = MUL_B_W'({1'b0, cc.gain});
				state_nx = W_AUX3;
			end
			W_AUX3: state_nx = w_q ? O_DIFF : W_SPD;
			O_DIFF: state_nx = O_MUL;
			O_MUL: begin
				mul_en   = 1'b1;
				mul_a    = MUL_A_W'(diff_q);
				mul_b    = B_INVWB;
				state_nx = O_ANG;
			end
			O_ANG: begin
				if (ld_out) begin
					state_nx = IDLE;
				end
			end
			default: state_nx = IDLE;
		endcase
	end

	// control, wheel state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q         <= 1'b0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
			wst_q[0]    <= '0;
			wst_q[1]    <= '0;
			wcfg_q[0]   <= '0;
			wcfg_q[1]   <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_FRIC_R:  wcfg_q[0].mu    <= wr_data;
					REG_DAMP_R:  wcfg_q[0].damp  <= wr_data;
					REG_DECAY_R: wcfg_q[0].decay <= wr_data;
					REG_GAIN_R:  wcfg_q[0].gain  <= wr_data;
					REG_FRIC_L:  wcfg_q[1].mu    <= wr_data;
					REG_DAMP_L:  wcfg_q[1].damp  <= wr_data;
					REG_DECAY_L: wcfg_q[1].decay <= wr_data;
					REG_GAIN_L:  wcfg_q[1].gain  <= wr_data;
					default: ;
				endcase
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (accept) begin
						w_q   <= 1'b0;
						sat_q <= 1'b0;
						if (new_case) begin
							wst_q[0] <= '{speed: init_right_speed, aux: init_right_aux};
							wst_q[1] <= '{speed: init_left_speed, aux: init_left_aux};
						end
					end
				end
				T_OM:    sat_q <= sat_q | om_s.clip;
				T_GAIN:  sat_q <= sat_q | gain_s.clip;
				T_RDRV:  sat_q <= sat_q | rdrv_s.clip;
				T_LDRV:  sat_q <= sat_q | ldrv_s.clip;
				W_SPEED: sat_q <= sat_q | sn_s.clip;
				W_AUX3: begin
					sat_q    <= sat_q | aux_s.clip;
					wst_q[w_q] <= '{speed: sn_q, aux: aux_s.val};
					w_q      <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload datapath
	always_ff @(posedge clk) begin
		case (state_q)
			IDLE: begin
				if (accept) begin
					fwd_q  <= joy_forward;
					turn_q <= joy_turn;
					gain_q <= GAIN_BYP;
				end
			end
			T_OM:   om_q   <= om_s.val;
			T_GAIN: gain_q <= gain_s.val;
			T_RDRV: begin
				drv_q[0] <= rdrv_s.val;
				acc_q    <= prx;
			end
			T_LDRV:  drv_q[1] <= ldrv_s.val;
			W_T:     t_q <= t_nx;
			W_CLAMP: f_q <= f_nx;
			W_M:     m_q <= m_nx;
			W_Q0:    q_q <= QD_W'(prod >>> RECIP_SH);
			W_R:     r_q <= r_nx;
			W_FIX: begin
				if (r_q < 0) begin
					q_q <= q_q - QD_W'(1);
					r_q <= r_q + DIV_Q;
				end else if (r_q >= DIV_Q) begin
					q_q <= q_q + QD_W'(1);
					r_q <= r_q - DIV_Q;
				end
			end
			W_SPEED: begin
				sn_q       <= sn_s.val;
				fric_q[w_q] <= f_q;
			end
			W_AUX1: acc_q  <= SUM_W'(cs.aux) - prx;
			W_AUX2: acc_q  <= acc_q - prx;
			O_DIFF: diff_q <= 33'(wst_q[0].speed) - 33'(wst_q[1].speed);
			O_ANG: begin
				if (ld_out) begin
					lin_q  <= lin_sum[32:1];
					ang_q  <= ang_s.val;
					lspd_q <= wst_q[1].speed;
					rspd_q <= wst_q[0].speed;
					ldrv_q <= drv_q[1];
					rdrv_q <= drv_q[0];
					lfr_q  <= fric_q[1];
					rfr_q  <= fric_q[0];
					osat_q <= sat_q | ang_s.clip;
				end
			end
			default: ;
		endcase
	end

	assign out_valid         = out_valid_q;
	assign linear_velocity   = lin_q;
	assign angular_velocity  = ang_q;
	assign left_wheel_speed  = lspd_q;
	assign right_wheel_speed = rspd_q;
	assign left_motor_drive  = ldrv_q;
	assign right_motor_drive = rdrv_q;
	assign left_friction     = lfr_q;
	assign right_friction    = rfr_q;
	assign saturated         = osat_q;

	a_hold_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == O_ANG && out_valid && out_stall) |=> (state_q == O_ANG && out_valid))
		else $error("finished item left the final state while the output beat was pending");

	a_fix_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == W_FIX) |-> (r_q > FIX_LO && r_q < FIX_HI))
		else $error("reciprocal quotient estimate off by more than the fix bound");

	a_rem_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == W_SPEED) |-> (r_q >= 0 && r_q < DIV_Q))
		else $error("speed update with remainder out of range");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ((state_q == T_RED || state_q == T_TURN) && !w_q && !sat_q))
		else $error("item start did not clear wheel select and clip flag");

	a_wheel_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == W_AUX3 && !w_q) |=> (state_q == W_SPD && w_q))
		else $error("left wheel pass did not follow right wheel pass");

endmodule
